>>> hw/rtl/perlin_noise_3d_top_macros.svh
// Assertion macros used by the noise block port checker.
`ifndef PERLIN_NOISE_3D_TOP_MACROS_SVH
`define PERLIN_NOISE_3D_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define PN3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define PN3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pn3_pkg.sv
// Package for the 3D gradient noise block: defaults, scale constant and permutation ROM.
`timescale 1ns / 1ps
package pn3_pkg;

	localparam int FRAC_BITS_DEF     = 16;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int COORD_W           = 24;
	localparam int NOISE_W           = 16;
	localparam int SCALE_Q16         = 63570;
	localparam int SCALE_BITS        = 16;
	localparam int LATENCY           = 7;

	localparam logic [7:0] PERM_ROM [256] = '{
		8'd63, 8'd9, 8'd212, 8'd205, 8'd31, 8'd128, 8'd72, 8'd59,
		8'd137, 8'd203, 8'd195, 8'd170, 8'd181, 8'd115, 8'd165, 8'd40,
		8'd116, 8'd139, 8'd175, 8'd225, 8'd132, 8'd99, 8'd222, 8'd2,
		8'd41, 8'd15, 8'd197, 8'd93, 8'd169, 8'd90, 8'd228, 8'd43,
		8'd221, 8'd38, 8'd206, 8'd204, 8'd73, 8'd17, 8'd97, 8'd10,
		8'd96, 8'd47, 8'd32, 8'd138, 8'd136, 8'd30, 8'd219,
		8'd78, 8'd224, 8'd13, 8'd193, 8'd88, 8'd134, 8'd211, 8'd7,
		8'd112, 8'd176, 8'd19, 8'd106, 8'd83, 8'd75, 8'd217, 8'd85,
		8'd0, 8'd98, 8'd140, 8'd229, 8'd80, 8'd118, 8'd151, 8'd117,
		8'd251, 8'd103, 8'd242, 8'd81, 8'd238, 8'd172, 8'd82, 8'd110,
		8'd4, 8'd227, 8'd77, 8'd243, 8'd46, 8'd12, 8'd189, 8'd34,
		8'd188, 8'd200, 8'd161, 8'd68, 8'd76, 8'd171, 8'd194,
		8'd57, 8'd48, 8'd247, 8'd233, 8'd51, 8'd105, 8'd5, 8'd23,
		8'd42, 8'd50, 8'd216, 8'd45, 8'd239, 8'd148, 8'd249, 8'd84,
		8'd70, 8'd125, 8'd108, 8'd241, 8'd62, 8'd66, 8'd64, 8'd240,
		8'd173, 8'd185, 8'd250, 8'd49, 8'd6, 8'd37, 8'd26, 8'd21,
		8'd244, 8'd60, 8'd223, 8'd255, 8'd16, 8'd145, 8'd27, 8'd109,
		8'd58, 8'd102, 8'd142, 8'd253, 8'd120, 8'd149, 8'd160,
		8'd124, 8'd156, 8'd79, 8'd186, 8'd135, 8'd127, 8'd14, 8'd121,
		8'd22, 8'd65, 8'd54, 8'd153, 8'd91, 8'd213, 8'd174, 8'd24,
		8'd252, 8'd131, 8'd192, 8'd190, 8'd202, 8'd208, 8'd35, 8'd94,
		8'd231, 8'd56, 8'd95, 8'd183, 8'd163, 8'd111, 8'd147, 8'd25,
		8'd67, 8'd36, 8'd92, 8'd236, 8'd71, 8'd166, 8'd1, 8'd187,
		8'd100, 8'd130, 8'd143, 8'd237, 8'd178, 8'd158,
		8'd104, 8'd184, 8'd159, 8'd177, 8'd52, 8'd214, 8'd230, 8'd119,
		8'd87, 8'd114, 8'd201, 8'd179, 8'd198, 8'd3, 8'd248, 8'd182,
		8'd39, 8'd11, 8'd152, 8'd196, 8'd113, 8'd20, 8'd232, 8'd69,
		8'd141, 8'd207, 8'd234, 8'd53, 8'd86, 8'd180, 8'd226, 8'd74,
		8'd150, 8'd218, 8'd29, 8'd133, 8'd8, 8'd44, 8'd123, 8'd28,
		8'd146, 8'd89, 8'd101, 8'd154, 8'd220, 8'd126,
		8'd155, 8'd122, 8'd210, 8'd168, 8'd254, 8'd162, 8'd129, 8'd33,
		8'd18, 8'd209, 8'd61, 8'd191, 8'd199, 8'd157, 8'd245, 8'd55,
		8'd164, 8'd167, 8'd215, 8'd246, 8'd144, 8'd107, 8'd235
	};

	// Permutation lookup; the 8-bit address wraps, as a doubled table would.
	function automatic logic [7:0] perm(input logic [7:0] addr);
		return PERM_ROM[addr];
	endfunction

endpackage

>>> hw/rtl/perlin_noise_3d_top.sv
// 3D gradient noise pipeline: lattice hashing, fade, trilinear blend, scale and clamp.
// Throughput: one request per cycle; busy is always low, as no stage ever stalls.
// Depth is set by the three dependent permutation ROM lookups and the blend multiplies.
// Reset clears only the stage valid bits; the data registers are not reset.
`timescale 1ns / 1ps
module perlin_noise_3d_top #(
	parameter int FRAC_BITS     = pn3_pkg::FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = pn3_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_x,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_y,
	input  logic [pn3_pkg::COORD_W-1:0]         coord_z,
	output logic                                noise_valid,
	output logic signed [pn3_pkg::NOISE_W-1:0]  noise_value
);
	import pn3_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int GW = F + 4;
	localparam int QW = F + 5;
	localparam int FW = F + 2;
	localparam int PW = GW + 18;
	localparam int SH = SCALE_BITS + F - OUT_FRAC_BITS;
	localparam logic signed [QW-1:0] P_OFF = QW'(15) <<< F;
	localparam logic signed [QW-1:0] Q_OFF = QW'(10) <<< F;
	localparam logic signed [GW-1:0] ONE_G = GW'(1) <<< F;
	localparam logic signed [PW-1:0] RND   = PW'(1) <<< (SH - 1);
	localparam logic signed [PW-1:0] LIM   = PW'(1) <<< OUT_FRAC_BITS;
	localparam logic signed [18:0]   SCALE = 19'(SCALE_Q16);

	// Gradient sum for one corner, picked by the low four hash bits.
	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
			input logic signed [GW-1:0] gx, input logic signed [GW-1:0] gy,
			input logic signed [GW-1:0] gz);
		logic signed [GW-1:0] r;
		case (h)
			4'd0:    r = gx + gz;
			4'd1:    r = gx + gy;
			4'd2:    r = gy + gz;
			4'd3:    r = -gx + gy;
			4'd4:    r = -gx + gz;
			4'd5:    r = -gx - gy;
			4'd6:    r = -gy + gz;
			4'd7:    r = gx - gy;
			4'd8:    r = gx - gz;
			4'd9:    r = gy - gz;
			4'd10:   r = -gx - gz;
			4'd11:   r = -gy - gz;
			4'd12:   r = gx + gy;
			4'd13:   r = -gx + gy;
			4'd14:   r = -gy + gz;
			default: r = -gy - gz;
		endcase
		return r;
	endfunction

	// Linear blend a + floor(wt * (b - a) / 2^F).
	function automatic logic signed [GW-1:0] lerp(input logic signed [GW-1:0] a,
			input logic signed [GW-1:0] b, input logic signed [FW-1:0] wt);
		logic signed [GW:0]      diff;
		logic signed [GW+FW:0]   prod;
		diff = {b[GW-1], b} - {a[GW-1], a};
		prod = diff * wt;
		return a + GW'(prod >>> F);
	endfunction

	logic [6:0] v_q;

	logic [F-1:0]          frac_c [3];
	logic [7:0]            lat_c  [3];
	logic [2*F-1:0]        sq_c   [3];
	logic signed [QW-1:0]  p_c    [3];
	logic signed [QW+F:0]  tp_c   [3];

	logic [7:0]            a_s1, b_s1, zi_s1;
	logic [F-1:0]          f_s1   [3];
	logic [F-1:0]          t2_s1  [3];
	logic signed [QW-1:0]  q_s1   [3];

	logic [7:0]            hb_s2  [4];
	logic [F-1:0]          f_s2   [3];
	logic [F-1:0]          t3_s2  [3];
	logic signed [QW-1:0]  q_s2   [3];

	logic signed [GW-1:0]  g_s3   [8];
	logic signed [FW-1:0]  fd_s3  [3];
	logic signed [GW-1:0]  lx_s4  [4];
	logic signed [FW-1:0]  fv_s4, fw_s4;
	logic signed [GW-1:0]  ly_s5  [2];
	logic signed [FW-1:0]  fw_s5;
	logic signed [GW-1:0]  n_s6;

	logic signed [PW-1:0]  sc_c, r_c;

	assign busy = 1'b0;

	// Stage 1 input: lattice indexes, fractions, and the first fade products.
	always_comb begin
		logic [31:0] cpad [3];
		cpad[0] = {8'b0, coord_x};
		cpad[1] = {8'b0, coord_y};
		cpad[2] = {8'b0, coord_z};
		for (int i = 0; i < 3; i++) begin
			lat_c[i]  = cpad[i][F +: 8];
			frac_c[i] = cpad[i][F-1:0];
			sq_c[i]   = frac_c[i] * frac_c[i];
			p_c[i]    = QW'({frac_c[i], 1'b0}) + QW'({frac_c[i], 2'b0}) - P_OFF;
			tp_c[i]   = $signed({1'b0, frac_c[i]}) * p_c[i];
		end
	end

	// Valid bits travel with the data through all seven stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[5:0], start & ~busy};
		end
	end

	// Stage registers; each stage holds at most one multiply level and one ROM lookup level.
	always_ff @(posedge clk) begin
		// Stage 1: first hash level and t^2, q.
		a_s1  <= perm(lat_c[0]) + lat_c[1];
		b_s1  <= perm(lat_c[0] + 8'd1) + lat_c[1];
		zi_s1 <= lat_c[2];
		for (int i = 0; i < 3; i++) begin
			f_s1[i]  <= frac_c[i];
			t2_s1[i] <= sq_c[i][2*F-1:F];
			q_s1[i]  <= QW'(tp_c[i] >>> F) + Q_OFF;
		end
		// Stage 2: second hash level and t^3.
		hb_s2[0] <= perm(a_s1) + zi_s1;
		hb_s2[1] <= perm(b_s1) + zi_s1;
		hb_s2[2] <= perm(a_s1 + 8'd1) + zi_s1;
		hb_s2[3] <= perm(b_s1 + 8'd1) + zi_s1;
		for (int i = 0; i < 3; i++) begin
			logic [2*F-1:0] cube;
			cube     = t2_s1[i] * f_s1[i];
			f_s2[i]  <= f_s1[i];
			t3_s2[i] <= cube[2*F-1:F];
			q_s2[i]  <= q_s1[i];
		end
		// Stage 3: corner hashes, gradient sums and the finished fade weights.
		for (int c = 0; c < 8; c++) begin
			logic signed [GW-1:0] gx, gy, gz;
			logic [7:0]           h;
			gx = GW'(f_s2[0]) - ((c % 2 == 1) ? ONE_G : GW'(0));
			gy = GW'(f_s2[1]) - (((c / 2) % 2 == 1) ? ONE_G : GW'(0));
			gz = GW'(f_s2[2]) - ((c / 4 == 1) ? ONE_G : GW'(0));
			h  = perm(hb_s2[c % 4] + 8'(c / 4));
			g_s3[c] <= grad(h[3:0], gx, gy, gz);
		end
		for (int i = 0; i < 3; i++) begin
			logic signed [QW+F:0] fp;
			fp        = $signed({1'b0, t3_s2[i]}) * q_s2[i];
			fd_s3[i]  <= FW'(fp >>> F);
		end
		// Stage 4: blends along x.
		for (int k = 0; k < 4; k++) begin
			lx_s4[k] <= lerp(g_s3[2*k], g_s3[2*k+1], fd_s3[0]);
		end
		fv_s4 <= fd_s3[1];
		fw_s4 <= fd_s3[2];
		// Stage 5: blends along y.
		ly_s5[0] <= lerp(lx_s4[0], lx_s4[1], fv_s4);
		ly_s5[1] <= lerp(lx_s4[2], lx_s4[3], fv_s4);
		fw_s5    <= fw_s4;
		// Stage 6: blend along z.
		n_s6 <= lerp(ly_s5[0], ly_s5[1], fw_s5);
		// Stage 7: scale, round, clamp.
		if (r_c > LIM) begin
			noise_value <= NOISE_W'(LIM);
		end else if (r_c < -LIM) begin
			noise_value <= NOISE_W'(-LIM);
		end else begin
			noise_value <= NOISE_W'(r_c);
		end
	end

	// Scale by 0.97 with round half up; the product is formed at full width.
	always_comb begin
		sc_c = PW'(n_s6) * PW'(SCALE);
		r_c  = (sc_c + RND) >>> SH;
	end

	assign noise_valid = v_q[6];

endmodule

>>> hw/rtl/pn3_checker.sv
// Port checker for the noise block, bound to the top level.
`timescale 1ns / 1ps
`include "perlin_noise_3d_top_macros.svh"
module pn3_checker #(
	parameter int OUT_FRAC_BITS = pn3_pkg::OUT_FRAC_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                noise_valid,
	input logic signed [pn3_pkg::NOISE_W-1:0]  noise_value
);
	import pn3_pkg::*;

	localparam int LIMV = (OUT_FRAC_BITS > 14) ? 0 : (1 << OUT_FRAC_BITS);

	// The pipeline never refuses a request.
	`PN3_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised")
	// Every result traces back to a request a fixed latency earlier.
	`PN3_ASSERT_NOW(a_latency, noise_valid, $past(start, LATENCY), "result without request")
	// A request leads to a result strobe after the pipeline depth.
	`PN3_ASSERT_NEXT(a_follow, start && !busy, ##(LATENCY - 1) noise_valid, "request lost")
	// Results stay within plus or minus one when OUT_FRAC_BITS is at most 14.
	`PN3_ASSERT_NOW(a_range, noise_valid && (OUT_FRAC_BITS <= 14),
		(noise_value <= LIMV) && (noise_value >= -LIMV), "noise out of range")

endmodule

bind perlin_noise_3d_top pn3_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_pn3_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.noise_valid(noise_valid),
	.noise_value(noise_value)
);
